/* rtl/rgbhsv_pkg.sv */
// rgb to hsv converter: shared widths, payload structs and pipeline state
// no dependencies
package rgbhsv_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int DEN_BITS      = CHANNEL_BITS + 3;
  localparam int SAT_BITS      = FRACTION_BITS + 1;
  localparam int NUM_STAGES    = FRACTION_BITS + 2;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [SAT_BITS-1:0]      saturation;
    logic [CHANNEL_BITS-1:0]  brightness;
  } hsv_pix_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [DEN_BITS-1:0]      hue_rem;
    logic [DEN_BITS-1:0]      hue_den;
    logic [CHANNEL_BITS-1:0]  sat_rem;
    logic [CHANNEL_BITS-1:0]  sat_den;
    logic [FRACTION_BITS-1:0] hue_q;
    logic [SAT_BITS-1:0]      sat_q;
    logic [CHANNEL_BITS-1:0]  brightness;
  } div_state_t;

endpackage

/* rtl/rgb_to_hsv_core.sv */
// rgb to hsv converter top level: front stages, divider pipeline, handshake
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_step
//
// Converts one 8-bit RGB pixel per clock, unless the pipeline is stalled, into
// hue (16-bit fraction of a turn), saturation (17 bits, 65536 means one) and
// brightness (largest channel). There are two front stages, then 16 stages of
// the hue and saturation restoring dividers, each stage producing one quotient bit.
// Each stage holds its transaction only while the stage after it is full
// and blocked, so bubbles are squeezed out and a stalled result does not
// stop new pixels from entering until the pipeline is full.
module rgb_to_hsv_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbhsv_pkg::rgb_pix_t  in_pix,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbhsv_pkg::hsv_pix_t  out_hsv
);
  import rgbhsv_pkg::*;

  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] vld;
  div_state_t            st [NUM_STAGES];

  assign en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;

  genvar k;
  generate
    for (k = 0; k < NUM_STAGES - 1; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate

  assign in_stall = !en[0];

  rgbhsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_a    (en[0]),
    .en_b    (en[1]),
    .vld_in  (in_valid),
    .pix_in  (in_pix),
    .vld_a_r (vld[0]),
    .vld_b_r (vld[1]),
    .st_r    (st[1])
  );

  // stage a carries no divider state
  assign st[0] = st[1];

  generate
    for (k = 2; k < NUM_STAGES; k++) begin : g_div
      rgbhsv_div_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en[k]),
        .vld_in (vld[k-1]),
        .st_in  (st[k-1]),
        .vld_r  (vld[k]),
        .st_r   (st[k])
      );
    end
  endgenerate

  assign out_valid          = vld[NUM_STAGES-1];
  assign out_hsv.hue        = st[NUM_STAGES-1].hue_q;
  assign out_hsv.saturation = st[NUM_STAGES-1].sat_q;
  assign out_hsv.brightness = st[NUM_STAGES-1].brightness;

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hsv.saturation <= (SAT_BITS'(1) << FRACTION_BITS))
    else $error("saturation above one");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hsv.brightness == '0 |-> out_hsv.saturation == '0)
    else $error("black pixel with nonzero saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hsv.saturation == '0 |-> out_hsv.hue == '0)
    else $error("grey pixel with nonzero hue");

  a_no_hold_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage is empty");

endmodule

/* rtl/rgbhsv_front.sv */
// rgb to hsv converter: two front stages, max/min and sector, then hue numerator,
// divisors and the integer quotient bit; depends on rgbhsv_pkg
module rgbhsv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en_a,
  input  logic                    en_b,
  input  logic                    vld_in,
  input  rgbhsv_pkg::rgb_pix_t    pix_in,
  output logic                    vld_a_r,
  output logic                    vld_b_r,
  output rgbhsv_pkg::div_state_t  st_r
);
  import rgbhsv_pkg::*;

  localparam int NW = DEN_BITS + 1;

  logic [CHANNEL_BITS-1:0] mx_nxt, mn_nxt, mx_r, mn_r;
  sector_t                 sec_nxt, sec_r;
  logic signed [CHANNEL_BITS:0] diff_nxt, diff_r;

  logic [CHANNEL_BITS-1:0] rg_max, rg_min;
  logic [CHANNEL_BITS-1:0] d;
  logic [DEN_BITS-1:0]     d_ext, d6, base;
  logic signed [NW-1:0]    num_s;
  logic                    grey, black, sat_one;
  div_state_t              st_nxt;

  // stage a: extremes and leading channel
  always_comb begin
    rg_max = (pix_in.red > pix_in.green) ? pix_in.red : pix_in.green;
    rg_min = (pix_in.red < pix_in.green) ? pix_in.red : pix_in.green;
    mx_nxt = (pix_in.blue > rg_max) ? pix_in.blue : rg_max;
    mn_nxt = (pix_in.blue < rg_min) ? pix_in.blue : rg_min;
    if (mx_nxt == pix_in.red) begin
      sec_nxt  = SEC_RED;
      diff_nxt = $signed({1'b0, pix_in.green}) - $signed({1'b0, pix_in.blue});
    end else if (mx_nxt == pix_in.green) begin
      sec_nxt  = SEC_GREEN;
      diff_nxt = $signed({1'b0, pix_in.blue}) - $signed({1'b0, pix_in.red});
    end else begin
      sec_nxt  = SEC_BLUE;
      diff_nxt = $signed({1'b0, pix_in.red}) - $signed({1'b0, pix_in.green});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en_a) begin
      vld_a_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      mx_r   <= mx_nxt;
      mn_r   <= mn_nxt;
      sec_r  <= sec_nxt;
      diff_r <= diff_nxt;
    end
  end

  // stage b: hue numerator in sixths of a turn, divisors, first quotient bit
  always_comb begin
    d     = mx_r - mn_r;
    d_ext = {3'b000, d};
    d6    = (d_ext << 2) + (d_ext << 1);
    unique case (sec_r)
      SEC_RED:   base = '0;
      SEC_GREEN: base = d_ext << 1;
      SEC_BLUE:  base = d_ext << 2;
      default:   base = '0;
    endcase
    num_s = $signed({1'b0, base}) + {{(NW-CHANNEL_BITS-1){diff_r[CHANNEL_BITS]}}, diff_r};
    if (sec_r == SEC_RED && diff_r < 0) begin
      num_s = num_s + $signed({1'b0, d6});
    end
    grey    = (d == '0);
    black   = (mx_r == '0);
    sat_one = (mn_r == '0) && !black;

    st_nxt.hue_rem    = grey ? '0 : num_s[DEN_BITS-1:0];
    st_nxt.hue_den    = grey ? DEN_BITS'(1) : d6;
    st_nxt.sat_den    = black ? CHANNEL_BITS'(1) : mx_r;
    st_nxt.sat_rem    = sat_one ? '0 : d;
    st_nxt.hue_q      = '0;
    st_nxt.sat_q      = {{FRACTION_BITS{1'b0}}, sat_one};
    st_nxt.brightness = mx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en_b) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/rgbhsv_div_step.sv */
// rgb to hsv converter: one registered restoring step of the hue and
// saturation dividers; depends on rgbhsv_pkg
module rgbhsv_div_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_in,
  input  rgbhsv_pkg::div_state_t  st_in,
  output logic                    vld_r,
  output rgbhsv_pkg::div_state_t  st_r
);
  import rgbhsv_pkg::*;

  logic [DEN_BITS:0]     hue_sh, hue_dif;
  logic [CHANNEL_BITS:0] sat_sh, sat_dif;
  logic                  hue_ge, sat_ge;
  div_state_t            st_nxt;

  always_comb begin
    hue_sh  = {st_in.hue_rem, 1'b0};
    hue_ge  = hue_sh >= {1'b0, st_in.hue_den};
    hue_dif = hue_sh - {1'b0, st_in.hue_den};
    sat_sh  = {st_in.sat_rem, 1'b0};
    sat_ge  = sat_sh >= {1'b0, st_in.sat_den};
    sat_dif = sat_sh - {1'b0, st_in.sat_den};

    st_nxt            = st_in;
    st_nxt.hue_rem    = hue_ge ? hue_dif[DEN_BITS-1:0] : hue_sh[DEN_BITS-1:0];
    st_nxt.sat_rem    = sat_ge ? sat_dif[CHANNEL_BITS-1:0] : sat_sh[CHANNEL_BITS-1:0];
    st_nxt.hue_q      = {st_in.hue_q[FRACTION_BITS-2:0], hue_ge};
    st_nxt.sat_q      = {st_in.sat_q[SAT_BITS-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* dv/rgbhsv_checker.sv */
// checker for the rgb to hsv core: watches both channels, predicts each pixel's hsv
// transaction and compares it with the block's output in arrival order
// depends on rgbhsv_pkg
module rgbhsv_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rgbhsv_pkg::rgb_pix_t in_pix,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rgbhsv_pkg::hsv_pix_t out_hsv,
  output int                   mismatches,
  output int                   pending
);
  import rgbhsv_pkg::*;

  hsv_pix_t hsv_expected_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic hsv_pix_t predict_hsv(rgb_pix_t p);
    longint unsigned r, g, b, mx, mn, d, num, hue, sat;
    hsv_pix_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0;
    sat = 0;
    num = 0;
    if (d != 0) begin
      // sector picked red, then green, then blue so ties go to the earlier channel
      if (mx == r) begin
        if (g >= b) num = g - b;
        else num = 6 * d - (b - g);
      end else if (mx == g) begin
        if (b >= r) num = 2 * d + (b - r);
        else num = 2 * d - (r - b);
      end else begin
        if (r >= g) num = 4 * d + (r - g);
        else num = 4 * d - (g - r);
      end
      hue = (num << FRACTION_BITS) / (6 * d);
    end
    if (mx != 0) sat = (d << FRACTION_BITS) / mx;
    res.hue        = hue[FRACTION_BITS-1:0];
    res.saturation = sat[SAT_BITS-1:0];
    res.brightness = mx[CHANNEL_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatches = mismatches + 1;
    if (mismatches <= 100) $display("%0t checker: %s", $time, what);
  endtask

  always @(posedge clk) begin
    hsv_pix_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) hsv_expected_q.push_back(predict_hsv(in_pix));
      if (out_valid && !out_stall) begin
        if (hsv_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction hue=%0d sat=%0d bright=%0d",
                                    out_hsv.hue, out_hsv.saturation, out_hsv.brightness));
        end else begin
          want = hsv_expected_q.pop_front();
          if (out_hsv.hue !== want.hue || out_hsv.saturation !== want.saturation ||
              out_hsv.brightness !== want.brightness)
            report_mismatch($sformatf("got hue=%0d sat=%0d bright=%0d, want %0d %0d %0d",
                                      out_hsv.hue, out_hsv.saturation, out_hsv.brightness,
                                      want.hue, want.saturation, want.brightness));
        end
      end
      pending = hsv_expected_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// testbench top for the rgb to hsv core: clock, reset, pixel stimulus with idling
// and result stalls, and the final verdict
// depends on rgbhsv_pkg, rgb_to_hsv_core and rgbhsv_checker
module tb;
  import rgbhsv_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rgb_pix_t in_pix = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hsv_pix_t out_hsv;
  int       mismatches;
  int       pending;
  int       idle_pct = 0;
  int       stall_pct = 0;

  rgb_to_hsv_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hsv   (out_hsv)
  );

  rgbhsv_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pix     (in_pix),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_hsv    (out_hsv),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic rgb_pix_t mk_pix(int r, int g, int b);
    rgb_pix_t p;
    p.red   = r[CHANNEL_BITS-1:0];
    p.green = g[CHANNEL_BITS-1:0];
    p.blue  = b[CHANNEL_BITS-1:0];
    return p;
  endfunction

  function automatic rgb_pix_t rand_pix();
    int mode;
    int v;
    rgb_pix_t p;
    mode = $urandom_range(0, 9);
    p = mk_pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    case (mode)
      5: begin
        v = $urandom_range(0, 255);
        p = mk_pix(v, v, v);
      end
      6: begin
        // two channels tied, third random
        v = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
          0: p = mk_pix(v, v, $urandom_range(0, 255));
          1: p = mk_pix(v, $urandom_range(0, 255), v);
          default: p = mk_pix($urandom_range(0, 255), v, v);
        endcase
      end
      7: p = mk_pix($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
      8: p = mk_pix($urandom_range(252, 255), $urandom_range(252, 255),
                    $urandom_range(252, 255));
      9: begin
        p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pix(rgb_pix_t p);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pix   <= p;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    rgb_pix_t directed[$];
    directed = '{
      mk_pix(0, 0, 0), mk_pix(255, 255, 255), mk_pix(128, 128, 128), mk_pix(1, 1, 1),
      mk_pix(255, 0, 0), mk_pix(0, 255, 0), mk_pix(0, 0, 255),
      mk_pix(255, 200, 10), mk_pix(255, 0, 1), mk_pix(200, 10, 199),
      mk_pix(10, 255, 200), mk_pix(200, 255, 10), mk_pix(10, 200, 255),
      mk_pix(200, 10, 255), mk_pix(255, 255, 0), mk_pix(0, 255, 255),
      mk_pix(255, 0, 255), mk_pix(1, 0, 0), mk_pix(0, 1, 0), mk_pix(0, 0, 1),
      mk_pix(255, 254, 0), mk_pix(254, 0, 255), mk_pix(170, 85, 85)
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pix(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (250) send_pix(rand_pix());
      // hold off until every pending transaction has come out
      drain();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
